>>> rtl/track_height_along_path_top_assert.svh
// ---------------------------------------------------------------------------
// track height assertion macros
// clocked on i_clk, disabled while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef TRACK_HEIGHT_ALONG_PATH_TOP_ASSERT_SVH
`define TRACK_HEIGHT_ALONG_PATH_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define TRK_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define TRK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/trk_pkg.sv
// ---------------------------------------------------------------------------
// trk_pkg
// widths, register indexes, shared types and saturation for the track
// height block
// ---------------------------------------------------------------------------
package trk_pkg;

    localparam int DATA_W     = 32;
    localparam int MAG_W      = 33;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int REM_W      = MAG_W + 1;
    localparam int ALU_W      = REM_W + 2;
    localparam int RND_BITS   = 16;
    localparam int DMAG_W     = PROD_W - RND_BITS;
    localparam int SUM_W      = DMAG_W + 2;
    localparam int CNT_W      = 6;
    localparam int IDX_W      = 2;
    localparam int IN_DATA_W  = 3 * DATA_W;
    localparam int OUT_DATA_W = 2 * DATA_W;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MAG_W - 1);

    localparam logic [IDX_W-1:0] REG_START_HEIGHT = 2'd0;
    localparam logic [IDX_W-1:0] REG_SLOPE        = 2'd1;
    localparam logic [IDX_W-1:0] REG_KINK_ARC     = 2'd2;
    localparam logic [IDX_W-1:0] REG_KINK_EN      = 2'd3;

    typedef struct packed {
        logic             ge;
        logic [ALU_W-1:0] diff;
    } t_csub_res;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi_lim;
        logic signed [SUM_W-1:0] lo_lim;
        hi_lim = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        lo_lim = {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
        if (v > hi_lim) begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < lo_lim) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return v[DATA_W-1:0];
        end
    endfunction

endpackage

>>> rtl/trk_mul.sv
// ---------------------------------------------------------------------------
// trk_mul
// unsigned 33 x 33 multiplier with a registered product
// ---------------------------------------------------------------------------
module trk_mul (
    input  logic                       i_clk,
    input  logic [trk_pkg::MAG_W-1:0]  i_a,
    input  logic [trk_pkg::MAG_W-1:0]  i_b,
    output logic [trk_pkg::PROD_W-1:0] o_p
);
    import trk_pkg::*;

    logic [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

>>> rtl/trk_csub.sv
// ---------------------------------------------------------------------------
// trk_csub
// compare and subtract step shared by the square root and the divider
// ---------------------------------------------------------------------------
module trk_csub (
    input  logic [trk_pkg::ALU_W-1:0] i_a,
    input  logic [trk_pkg::ALU_W-1:0] i_b,
    output trk_pkg::t_csub_res        o_res
);
    import trk_pkg::*;

    logic [ALU_W:0] diff_ext;

    assign diff_ext   = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.ge   = ~diff_ext[ALU_W];
    assign o_res.diff = diff_ext[ALU_W-1:0];

endmodule

>>> rtl/track_height_along_path_top.sv
// ---------------------------------------------------------------------------
// track_height_along_path_top
// height of each point of a planar track from step length and slope,
// with a one-time linear kink height per track
//
//   channel   dir  payload
//   s_axis    in   tdata x/y/arc, tuser first point, tlast last point
//   m_axis    out  tdata height/kink height, tuser kink found, tlast end
//   cfg       in   write enable, 2-bit index, 32-bit data
//
// a first point goes from idle straight to the final state, which loads the
// result register; a later point also runs 33 square root steps on the shared
// compare/subtract unit plus multiplier passes; a kink step adds 33 divide steps
// input ready returns the cycle after the result register loads
// a stalled output holds the next result in the final state
// reset clears config, track state and all handshake control
// ---------------------------------------------------------------------------
`include "track_height_along_path_top_assert.svh"

module track_height_along_path_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [trk_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // point_x, point_y, arc_length
    input  logic                           s_axis_tuser,   // first_point
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [trk_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // height, kink_height
    output logic                           m_axis_tuser,   // kink_found
    output logic                           m_axis_tlast,
    input  logic                           i_cfg_we,
    input  logic [trk_pkg::IDX_W-1:0]      i_cfg_idx,
    input  logic [trk_pkg::DATA_W-1:0]     i_cfg_data
);
    import trk_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MX, ST_MY, ST_SUM, ST_SQRT, ST_MS, ST_RND, ST_HGT,
        ST_KSET, ST_KMUL, ST_KADD, ST_DIV, ST_KFIN, ST_FIN
    } t_state;

    t_state r_state;

    logic signed [DATA_W-1:0] r_start_height, r_slope, r_kink_arc;
    logic                     r_kink_en;
    logic signed [DATA_W-1:0] r_prev_x, r_prev_y, r_prev_arc, r_prev_height;
    logic                     r_kink_known;
    logic signed [DATA_W-1:0] r_kink_value;
    logic signed [DATA_W-1:0] r_in_x, r_in_y, r_in_s;
    logic                     r_in_last;
    logic [MAG_W-1:0]         r_ax, r_ay, r_q, r_num, r_den, r_dzmag;
    logic                     r_dzneg;
    logic [PROD_W-1:0]        r_rad;
    logic [REM_W-1:0]         r_rem;
    logic [CNT_W-1:0]         r_cnt;
    logic [DMAG_W-1:0]        r_dmag;
    logic signed [DATA_W-1:0] r_h;
    logic                     r_out_valid, r_out_kf, r_out_last;
    logic [DATA_W-1:0]        r_out_height, r_out_kh;

    logic signed [DATA_W-1:0] in_x, in_y, in_s;
    logic signed [MAG_W-1:0]  dx, dy, dz, num_d, den_d;
    logic [MAG_W-1:0]         ax_mag, ay_mag, slope_mag, dz_mag;
    logic [MAG_W-1:0]         mul_a, mul_b;
    logic [PROD_W-1:0]        prod, rnd_sum, n_sum;
    logic [ALU_W-1:0]         alu_a, alu_b;
    t_csub_res                alu_res;
    logic signed [SUM_W-1:0]  base, hgt_sum, kink_sum;
    logic                     kink_hit;

    assign in_x = s_axis_tdata[DATA_W-1:0];
    assign in_y = s_axis_tdata[2*DATA_W-1:DATA_W];
    assign in_s = s_axis_tdata[3*DATA_W-1:2*DATA_W];

    assign dx     = {in_x[DATA_W-1], in_x} - {r_prev_x[DATA_W-1], r_prev_x};
    assign dy     = {in_y[DATA_W-1], in_y} - {r_prev_y[DATA_W-1], r_prev_y};
    assign ax_mag = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    assign ay_mag = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);

    assign slope_mag = r_slope[DATA_W-1] ? MAG_W'(-{r_slope[DATA_W-1], r_slope})
                                         : MAG_W'({1'b0, r_slope});

    assign dz     = {r_h[DATA_W-1], r_h} - {r_prev_height[DATA_W-1], r_prev_height};
    assign dz_mag = dz[MAG_W-1] ? MAG_W'(-dz) : MAG_W'(dz);
    assign num_d  = {r_kink_arc[DATA_W-1], r_kink_arc} - {r_prev_arc[DATA_W-1], r_prev_arc};
    assign den_d  = {r_in_s[DATA_W-1], r_in_s} - {r_prev_arc[DATA_W-1], r_prev_arc};

    assign kink_hit = r_kink_en && !r_kink_known &&
                      (r_kink_arc >= r_prev_arc) && (r_kink_arc < r_in_s);

    always_comb begin
        unique case (r_state)
            ST_MX: begin
                mul_a = r_ax;
                mul_b = r_ax;
            end
            ST_MY: begin
                mul_a = r_ay;
                mul_b = r_ay;
            end
            ST_MS: begin
                mul_a = r_q;
                mul_b = slope_mag;
            end
            ST_KMUL: begin
                mul_a = r_num;
                mul_b = r_dzmag;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    trk_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // square root step: remainder gets the next bit pair, trial is 4*root+1
    // divide step: remainder gets the next dividend bit, trial is the divisor
    always_comb begin
        if (r_state == ST_SQRT) begin
            alu_a = {r_rem, r_rad[PROD_W-1:PROD_W-2]};
            alu_b = {1'b0, r_q, 2'b01};
        end else begin
            alu_a = {1'b0, r_rem, r_rad[PROD_W-1]};
            alu_b = {3'b000, r_den};
        end
    end

    trk_csub u_csub (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    assign rnd_sum  = prod + PROD_W'(1 << (RND_BITS - 1));
    assign n_sum    = prod + {{(PROD_W-MAG_W+1){1'b0}}, r_den[MAG_W-1:1]};
    assign base     = {{(SUM_W-DATA_W){r_prev_height[DATA_W-1]}}, r_prev_height};
    assign hgt_sum  = r_slope[DATA_W-1] ? base - {{(SUM_W-DMAG_W){1'b0}}, r_dmag}
                                        : base + {{(SUM_W-DMAG_W){1'b0}}, r_dmag};
    assign kink_sum = r_dzneg ? base - {{(SUM_W-MAG_W){1'b0}}, r_q}
                              : base + {{(SUM_W-MAG_W){1'b0}}, r_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_out_valid    <= 1'b0;
            r_start_height <= '0;
            r_slope        <= '0;
            r_kink_arc     <= '0;
            r_kink_en      <= 1'b0;
            r_prev_x       <= '0;
            r_prev_y       <= '0;
            r_prev_arc     <= '0;
            r_prev_height  <= '0;
            r_kink_known   <= 1'b0;
            r_kink_value   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_START_HEIGHT: r_start_height <= i_cfg_data;
                    REG_SLOPE:        r_slope        <= i_cfg_data;
                    REG_KINK_ARC:     r_kink_arc     <= i_cfg_data;
                    REG_KINK_EN:      r_kink_en      <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // the final state reloads the register itself when it is taken
            if (r_out_valid && m_axis_tready && (r_state != ST_FIN)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_in_x    <= in_x;
                        r_in_y    <= in_y;
                        r_in_s    <= in_s;
                        r_in_last <= s_axis_tlast;
                        if (s_axis_tuser) begin
                            r_h          <= r_start_height;
                            r_kink_known <= 1'b0;
                            r_kink_value <= '0;
                            r_state      <= ST_FIN;
                        end else begin
                            r_ax    <= ax_mag;
                            r_ay    <= ay_mag;
                            r_state <= ST_MX;
                        end
                    end
                end
                ST_MX: begin
                    r_state <= ST_MY;
                end
                ST_MY: begin
                    r_rad   <= prod;
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_rad   <= r_rad + prod;
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_SQRT;
                end
                ST_SQRT: begin
                    r_rem <= alu_res.ge ? alu_res.diff[REM_W-1:0] : alu_a[REM_W-1:0];
                    r_q   <= {r_q[MAG_W-2:0], alu_res.ge};
                    r_rad <= r_rad << 2;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_state <= ST_MS;
                    end
                end
                ST_MS: begin
                    r_state <= ST_RND;
                end
                ST_RND: begin
                    r_dmag  <= rnd_sum[PROD_W-1:RND_BITS];
                    r_state <= ST_HGT;
                end
                ST_HGT: begin
                    r_h     <= sat32(hgt_sum);
                    r_state <= ST_KSET;
                end
                ST_KSET: begin
                    r_num   <= MAG_W'(num_d);
                    r_den   <= MAG_W'(den_d);
                    r_dzmag <= dz_mag;
                    r_dzneg <= dz[MAG_W-1];
                    r_state <= kink_hit ? ST_KMUL : ST_FIN;
                end
                ST_KMUL: begin
                    r_state <= ST_KADD;
                end
                ST_KADD: begin
                    // rounded dividend: upper part seeds the remainder
                    r_rem   <= {1'b0, n_sum[PROD_W-1:MAG_W]};
                    r_rad   <= {n_sum[MAG_W-1:0], {MAG_W{1'b0}}};
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem <= alu_res.ge ? alu_res.diff[REM_W-1:0] : alu_a[REM_W-1:0];
                    r_q   <= {r_q[MAG_W-2:0], alu_res.ge};
                    r_rad <= r_rad << 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_state <= ST_KFIN;
                    end
                end
                ST_KFIN: begin
                    r_kink_value <= sat32(kink_sum);
                    r_kink_known <= 1'b1;
                    r_state      <= ST_FIN;
                end
                ST_FIN: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid   <= 1'b1;
                        r_out_height  <= r_h;
                        r_out_kf      <= r_kink_known;
                        r_out_kh      <= r_kink_known ? r_kink_value : '0;
                        r_out_last    <= r_in_last;
                        r_prev_x      <= r_in_x;
                        r_prev_y      <= r_in_y;
                        r_prev_arc    <= r_in_s;
                        r_prev_height <= r_h;
                        r_state       <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_kh, r_out_height};
    assign m_axis_tuser  = r_out_kf;
    assign m_axis_tlast  = r_out_last;

    `TRK_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "input ready right after a transaction")
    `TRK_ASSERT_SAME(a_no_kink_zero, m_axis_tvalid && !m_axis_tuser,
        m_axis_tdata[OUT_DATA_W-1:DATA_W] == '0, "kink height set without kink found")
    `TRK_ASSERT_SAME(a_div_rem_bound, r_state == ST_DIV, r_rem < REM_W'(r_den),
        "divider remainder not below divisor")
    `TRK_ASSERT_NEXT(a_fin_holds, r_state == ST_FIN && m_axis_tvalid && !m_axis_tready,
        r_state == ST_FIN, "result dropped while output stalled")

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: track height along path testbench
// drives point transactions through track_height_along_path_top and checks
// every result against a cycle-free predictor (or typed row values) of the
// height, kink and track-end fields; a short directed table (extremes,
// saturation, kink boundaries, rounding, track marks) runs first, then random
// tracks under several register settings with random gaps on both sides
// ----------------------------------------------------------------------------
module tb;
    import trk_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 200;
    localparam int N_DIR_ROWS     = 38;

    typedef struct packed {
        logic [31:0] height;
        logic        kink_found;
        logic [31:0] kink_height;
        logic        track_end;
    } t_height_result;

    typedef enum logic {ROW_CFG, ROW_POINT} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic [IDX_W-1:0] idx;
        logic [31:0]      a;
        logic [31:0]      b;
        logic [31:0]      c;
        logic             first;
        logic             last;
        logic             typed;
        t_height_result   want;
    } t_stim_row;

    // cfg rows: idx, a = data; point rows: a = x, b = y, c = arc length
    t_stim_row dir_rows [N_DIR_ROWS] = '{
        '{ROW_POINT, '0, 32'd3072, 32'd4096, 32'd5120, 1'b0, 1'b0, 1'b1,
          '{32'h0, 1'b0, 32'h0, 1'b0}},
        '{ROW_CFG, REG_START_HEIGHT, 32'h7fffffff, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_SLOPE, 32'h7fffffff, '0, '0, '0, '0, '0, '0},
        '{ROW_POINT, '0, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1, 1'b1, 1'b1,
          '{32'h7fffffff, 1'b0, 32'h0, 1'b1}},
        '{ROW_POINT, '0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, 1'b0, 1'b1,
          '{32'h7fffffff, 1'b0, 32'h0, 1'b0}},
        '{ROW_CFG, REG_START_HEIGHT, 32'h80000000, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_SLOPE, 32'h80000000, '0, '0, '0, '0, '0, '0},
        '{ROW_POINT, '0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 1'b1,
          '{32'h80000000, 1'b0, 32'h0, 1'b0}},
        '{ROW_POINT, '0, 32'h7fffffff, 32'h80000000, 32'd100, 1'b0, 1'b1, 1'b1,
          '{32'h80000000, 1'b0, 32'h0, 1'b1}},
        '{ROW_POINT, '0, 32'h0, 32'h0, 32'd200, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_CFG, REG_START_HEIGHT, 32'h0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_SLOPE, 32'h00010000, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_KINK_ARC, 32'd2560, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_KINK_EN, 32'd1, '0, '0, '0, '0, '0, '0},
        '{ROW_POINT, '0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 1'b1,
          '{32'h0, 1'b0, 32'h0, 1'b0}},
        '{ROW_POINT, '0, 32'd3072, 32'd4096, 32'd5120, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_POINT, '0, 32'd6144, 32'd8192, 32'd10240, 1'b0, 1'b1, 1'b0, '0},
        '{ROW_POINT, '0, 32'h0, 32'h0, 32'd2560, 1'b1, 1'b0, 1'b1,
          '{32'h0, 1'b0, 32'h0, 1'b0}},
        '{ROW_POINT, '0, 32'h0, 32'd1, 32'd2560, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_POINT, '0, 32'h0, 32'd2, 32'd3000, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_POINT, '0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_POINT, '0, 32'h0, 32'h0, 32'd2560, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_CFG, REG_SLOPE, 32'h00008000, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_KINK_EN, 32'd0, '0, '0, '0, '0, '0, '0},
        '{ROW_POINT, '0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1, 1'b1,
          '{32'h0, 1'b0, 32'h0, 1'b1}},
        '{ROW_POINT, '0, 32'd1, 32'h0, 32'd5000, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_CFG, REG_SLOPE, 32'hffff8000, '0, '0, '0, '0, '0, '0},
        '{ROW_POINT, '0, 32'd3, 32'h0, 32'd6000, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_CFG, REG_KINK_ARC, 32'h0, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_KINK_EN, 32'd1, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_SLOPE, 32'h7fffffff, '0, '0, '0, '0, '0, '0},
        '{ROW_POINT, '0, 32'h0, 32'h0, 32'h80000000, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_POINT, '0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, 1'b1, 1'b0, '0},
        '{ROW_CFG, REG_KINK_ARC, 32'h80000000, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_SLOPE, 32'h80000000, '0, '0, '0, '0, '0, '0},
        '{ROW_CFG, REG_START_HEIGHT, 32'h7fffffff, '0, '0, '0, '0, '0, '0},
        '{ROW_POINT, '0, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1, 1'b0, 1'b1,
          '{32'h7fffffff, 1'b0, 32'h0, 1'b0}},
        '{ROW_POINT, '0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, 1'b1, 1'b0, '0}
    };

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // point_x, point_y, arc_length
    logic                  s_axis_tuser  = 1'b0; // first_point
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // height, kink_height
    logic                  m_axis_tuser;         // kink_found
    logic                  m_axis_tlast;
    logic                  i_cfg_we      = 1'b0;
    logic [IDX_W-1:0]      i_cfg_idx     = '0;
    logic [DATA_W-1:0]     i_cfg_data    = '0;

    logic steady = 1'b0;
    int   mismatches = 0;
    int   stall_cycles = 0;

    t_height_result heights_due[$];
    t_height_result due_now;

    // predictor copy of registers and track state
    logic signed [31:0] cfg_start    = '0;
    logic signed [31:0] cfg_slope    = '0;
    logic signed [31:0] cfg_kink_arc = '0;
    logic               cfg_kink_en  = 1'b0;
    logic signed [31:0] last_x       = '0;
    logic signed [31:0] last_y       = '0;
    logic signed [31:0] last_arc     = '0;
    logic signed [31:0] last_height  = '0;
    logic               kink_seen    = 1'b0;
    logic signed [31:0] kink_z       = '0;

    track_height_along_path_top i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [32:0] isqrt66(input logic [65:0] v);
        logic [67:0] rem;
        logic [67:0] trial;
        logic [33:0] root;
        rem  = '0;
        root = '0;
        for (int i = 32; i >= 0; i--) begin
            rem   = (rem << 2) | 68'(v[2*i +: 2]);
            trial = 68'({root, 2'b01});
            if (rem >= trial) begin
                rem  = rem - trial;
                root = {root[32:0], 1'b1};
            end else begin
                root = root << 1;
            end
        end
        return root[32:0];
    endfunction

    function automatic logic signed [31:0] clamp_s32(input logic signed [79:0] v);
        if (v > 80'sd2147483647) begin
            return 32'h7fffffff;
        end else if (v < -80'sd2147483648) begin
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_height_result compute_point_height(
        input logic signed [31:0] px, py, pa, input logic fp, lp);
        logic signed [32:0] dx, dy, num, den, dz;
        logic [32:0]        ax, ay, dz_mag, len;
        logic [31:0]        slope_mag;
        logic [79:0]        prod, dmag, kq;
        logic signed [79:0] delta, off;
        logic signed [31:0] h;
        t_height_result     r;
        if (fp) begin
            h         = cfg_start;
            kink_seen = 1'b0;
            kink_z    = '0;
        end else begin
            dx        = 33'(px) - 33'(last_x);
            dy        = 33'(py) - 33'(last_y);
            ax        = dx[32] ? -dx : dx;
            ay        = dy[32] ? -dy : dy;
            len       = isqrt66(66'(ax) * 66'(ax) + 66'(ay) * 66'(ay));
            slope_mag = cfg_slope[31] ? -cfg_slope : cfg_slope;
            prod      = 80'(len) * 80'(slope_mag);
            dmag      = (prod + 80'h8000) >> 16;
            delta     = cfg_slope[31] ? -$signed(dmag) : $signed(dmag);
            h         = clamp_s32(80'(last_height) + delta);
            if (cfg_kink_en && !kink_seen && cfg_kink_arc >= last_arc && cfg_kink_arc < pa) begin
                num       = 33'(cfg_kink_arc) - 33'(last_arc);
                den       = 33'(pa) - 33'(last_arc);
                dz        = 33'(h) - 33'(last_height);
                dz_mag    = dz[32] ? -dz : dz;
                kq        = (80'(num) * 80'(dz_mag) + (80'(den) >> 1)) / 80'(den);
                off       = dz[32] ? -$signed(kq) : $signed(kq);
                kink_z    = clamp_s32(80'(last_height) + off);
                kink_seen = 1'b1;
            end
        end
        last_x        = px;
        last_y        = py;
        last_arc      = pa;
        last_height   = h;
        r.height      = h;
        r.kink_found  = kink_seen;
        r.kink_height = kink_seen ? kink_z : '0;
        r.track_end   = lp;
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %h, actual %h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_START_HEIGHT: cfg_start    = val;
            REG_SLOPE:        cfg_slope    = val;
            REG_KINK_ARC:     cfg_kink_arc = val;
            REG_KINK_EN:      cfg_kink_en  = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (heights_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_point(input logic signed [31:0] px, py, pa, input logic fp, lp,
                              input logic typed, input t_height_result want);
        t_height_result pred;
        i_cfg_we <= 1'b0;
        while (!steady && $urandom_range(0, 99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pa, py, px};
        s_axis_tuser  <= fp;
        s_axis_tlast  <= lp;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pred = compute_point_height(px, py, pa, fp, lp);
        heights_due.insert(heights_due.size(), typed ? want : pred);
    endtask

    task automatic load_phase_regs(input int phase);
        logic [31:0] sh, sl, ka;
        logic        ke;
        case ($urandom_range(0, 3))
            0:       sh = $urandom;
            default: sh = $urandom_range(0, 400000) - 200000;
        endcase
        case ($urandom_range(0, 5))
            0:       sl = $urandom;
            1:       sl = '0;
            2:       sl = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: sl = $urandom_range(0, 32'h60000) - 32'h30000;
        endcase
        ka = $urandom_range(0, 80000) - 20000;
        ke = ($urandom_range(0, 3) != 0);
        if (phase == 1) begin
            sh = 32'h7fffffff;
            sl = 32'h7fffffff;
            ka = 32'h7fffffff;
        end
        if (phase == 2) begin
            sh = 32'h80000000;
            sl = 32'h80000000;
            ka = 32'h80000000;
        end
        wait_drained();
        write_reg(REG_START_HEIGHT, sh);
        write_reg(REG_SLOPE, sl);
        write_reg(REG_KINK_ARC, ka);
        write_reg(REG_KINK_EN, {31'd0, ke});
    endtask

    // mostly well-formed tracks with short steps, some noisy marks and jumps
    task automatic run_random_phase(input int n_items);
        int                 sent;
        int                 pts;
        logic signed [31:0] px, py, pa;
        logic               fp, lp;
        sent = 0;
        while (sent < n_items) begin
            pts = $urandom_range(1, 10);
            px  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 200000) - 100000;
            py  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 200000) - 100000;
            pa  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40000) - 20000;
            for (int k = 0; k < pts; k++) begin
                fp = (k == 0);
                lp = (k == pts - 1);
                if ($urandom_range(0, 99) < 8) begin
                    fp = 1'($urandom_range(0, 1));
                    lp = 1'($urandom_range(0, 1));
                end
                send_point(px, py, pa, fp, lp, 1'b0, '0);
                sent++;
                px = ($urandom_range(0, 9) == 0) ? $urandom : px + $urandom_range(0, 16384) - 8192;
                py = ($urandom_range(0, 9) == 0) ? $urandom : py + $urandom_range(0, 16384) - 8192;
                case ($urandom_range(0, 19))
                    0:       pa = $urandom;
                    1:       pa = pa - $urandom_range(0, 5000);
                    default: pa = pa + $urandom_range(0, 12000);
                endcase
            end
        end
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 7);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (heights_due.size() == 0) begin
                $display("%0t unexpected result transaction: expected none, actual height %h",
                         $time, m_axis_tdata[31:0]);
                mismatches++;
            end else begin
                due_now = heights_due.pop_front();
                check_field("height", due_now.height, m_axis_tdata[31:0]);
                check_field("kink_found", 32'(due_now.kink_found), 32'(m_axis_tuser));
                check_field("kink_height", due_now.kink_height, m_axis_tdata[63:32]);
                check_field("track_end", 32'(due_now.track_end), 32'(m_axis_tlast));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("track_height_along_path_top verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                wait_drained();
                write_reg(dir_rows[r].idx, dir_rows[r].a);
            end else begin
                send_point(dir_rows[r].a, dir_rows[r].b, dir_rows[r].c, dir_rows[r].first,
                           dir_rows[r].last, dir_rows[r].typed, dir_rows[r].want);
            end
        end
        for (int ph = 0; ph < PHASES; ph++) begin
            steady <= (ph == 3);
            load_phase_regs(ph);
            run_random_phase(PHASE_ITEMS);
        end
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("track_height_along_path_top verification clean");
        end else begin
            $display("track_height_along_path_top verification failed");
        end
        $finish;
    end

endmodule
